@@ sv/barometric_pressure_compensation_top_assert.svh @@
// assertion macros used by the checker file
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// types, constants and helpers of the pressure compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;
  localparam int unsigned NumCfg = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OvsFixed = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CfgAc1Ac2 = 3'd0,
    CfgAc3Ac4 = 3'd1,
    CfgAc5Ac6 = 3'd2,
    CfgB1B2   = 3'd3,
    CfgMcMd   = 3'd4
  } cfg_idx_e;
  localparam logic [31:0] C4000  = 32'd4000;
  localparam logic [31:0] C32768 = 32'd32768;
  localparam logic [31:0] C50000 = 32'd50000;
  localparam logic [31:0] CSign  = 32'h8000_0000;
  localparam logic [31:0] C3038  = 32'd3038;
  localparam logic [31:0] CM7357 = -32'sd7357;
  localparam logic [31:0] C3791  = 32'd3791;
  typedef struct packed {
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  } cal_t;
  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
  } item_t;
  typedef struct packed {
    logic [31:0] p;
    logic        err;
  } res_t;
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage

@@ sv/bpc_divider.sv @@
// ----------------------------------------------------------------------------
// bpc_divider
// unsigned 32-bit radix-2 pipelined divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_divider #(
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     num_i,
  input  logic [31:0]     den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [31:0]     quo_o,
  output logic [TagW-1:0] tag_o
);
  logic [32:0]     vld_q;
  logic [31:0]     rem_q [33];
  logic [31:0]     num_q [33];
  logic [31:0]     den_q [33];
  logic [TagW-1:0] tag_q [33];

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < 32; s++) begin : g_stage
    logic [32:0] trial;
    assign trial = {rem_q[s], num_q[s][31]} - {1'b0, den_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[32]) begin
          rem_q[s+1] <= trial[31:0];
          num_q[s+1] <= {num_q[s][30:0], 1'b1};
        end else begin
          rem_q[s+1] <= {rem_q[s][30:0], num_q[s][31]};
          num_q[s+1] <= {num_q[s][30:0], 1'b0};
        end
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  assign valid_o = vld_q[32];
  assign quo_o   = num_q[32];
  assign tag_o   = tag_q[32];
endmodule

@@ sv/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// temperature path: x1, temperature divide, b5
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  bpc_pkg::item_t item_i,
  input  bpc_pkg::cal_t  cal_i,
  output logic          valid_o,
  output logic [31:0]   b5_o,
  output logic [23:0]   up_o,
  output logic          err_o
);
  import bpc_pkg::*;
  localparam int unsigned TagW = 32 + 24 + 3;

  logic        v1_q;
  logic [31:0] prod_q;
  logic [23:0] up1_q;
  logic        v2_q;
  logic [31:0] x1_q, den_q, num_q;
  logic [23:0] up2_q;
  logic [31:0] x1a;
  logic [31:0] mden, mnum;
  logic [TagW-1:0] tag_in, tag_out;
  logic        dv;
  logic [31:0] quo;
  logic        neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign x1a = {{15{prod_q[31]}}, prod_q[31:15]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ({16'd0, item_i.ut} - cal_i.ac6) * cal_i.ac5;
      up1_q  <= item_i.up;
      x1_q   <= x1a;
      den_q  <= x1a + cal_i.md;
      num_q  <= {cal_i.mc[20:0], 11'd0};
      up2_q  <= up1_q;
    end
  end

  assign mden = den_q[31] ? 32'd0 - den_q : den_q;
  assign mnum = num_q[31] ? 32'd0 - num_q : num_q;
  assign tag_in = {x1_q, up2_q, num_q[31] ^ den_q[31], den_q == '0, 1'b0};

  bpc_divider #(.TagW(TagW)) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v2_q), .num_i(mnum), .den_i(mden), .tag_i(tag_in),
    .valid_o(dv), .quo_o(quo), .tag_o(tag_out)
  );

  assign neg     = tag_out[2];
  assign valid_o = dv;
  assign b5_o    = tag_out[58:27] + (neg ? 32'd0 - quo : quo);
  assign up_o    = tag_out[26:3];
  assign err_o   = tag_out[1] | tag_out[0];
endmodule

@@ sv/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// pressure path: b6 to b7, pressure divide and final correction
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   b5_i,
  input  logic [23:0]   up_i,
  input  logic          err_i,
  input  bpc_pkg::cal_t  cal_i,
  output logic          valid_o,
  output bpc_pkg::res_t  res_o
);
  import bpc_pkg::*;
  localparam int unsigned TagW = 2;

  logic        v1_q, v2_q, v3_q, v4_q, v4b_q, v5_q, v6_q, v7_q;
  logic        e1_q, e2_q, e3_q, e4_q, e4b_q;
  logic [31:0] b6_q, sqp_q, ac2b6_q, ac3b6_q;
  logic [19:0] up1_q, up2_q, up3_q, up4_q;
  logic [31:0] b2sq_q, b1sq_q, ac2b6b_q, ac3b6b_q;
  logic [31:0] b3_q, x3_q;
  logic [31:0] b4_q, b7_q;
  logic [31:0] b3c, x3c;
  logic        b7lo;
  logic [31:0] num, den;
  logic [TagW-1:0] tag_in, tag_out;
  logic        dv;
  logic [31:0] quo;
  logic [31:0] p5_q, tt_q, x2p_q;
  logic [31:0] pa, pf;
  logic        e5_q, e6_q, e7_q;
  logic [31:0] p6_q, x1_q, x2_q;
  logic [31:0] x1m_q, p7_q, x2b_q;
  logic [31:0] sqa;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v4b_q, v5_q, v6_q, v7_q} <= '0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v4b_q <= v4_q; v5_q <= dv; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  assign sqa = {{12{sqp_q[31]}}, sqp_q[31:12]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: b6
      b6_q  <= b5_i - C4000;
      up1_q <= 20'(up_i >> (8 - OvsFixed));
      e1_q  <= err_i;
      // stage 2: products on b6
      sqp_q   <= b6_q * b6_q;
      ac2b6_q <= cal_i.ac2 * b6_q;
      ac3b6_q <= cal_i.ac3 * b6_q;
      up2_q   <= up1_q;
      e2_q    <= e1_q;
      // stage 3: products on sq
      b2sq_q   <= cal_i.b2 * sqa;
      b1sq_q   <= cal_i.b1 * sqa;
      ac2b6b_q <= ac2b6_q;
      ac3b6b_q <= ac3b6_q;
      up3_q    <= up2_q;
      e3_q     <= e2_q;
      // stage 4: b3 and x3
      b3_q  <= b3c;
      x3_q  <= x3c;
      up4_q <= up3_q;
      e4_q  <= e3_q;
      // stage 5: b4 and b7
      b4_q  <= (cal_i.ac4 * (x3_q + C32768)) >> 15;
      b7_q  <= ({12'd0, up4_q} - b3_q) * (C50000 >> OvsFixed);
      e4b_q <= e4_q;
    end
  end

  always_comb begin
    logic [31:0] x3a, t;
    x3a = {{11{b2sq_q[31]}}, b2sq_q[31:11]} + {{11{ac2b6b_q[31]}}, ac2b6b_q[31:11]};
    t   = ((cal_i.ac1 * 32'd4 + x3a) << OvsFixed) + 32'd2;
    b3c = {{2{t[31]}}, t[31:2]};
    t   = {{13{ac3b6b_q[31]}}, ac3b6b_q[31:13]} + {{16{b1sq_q[31]}}, b1sq_q[31:16]}
          + 32'd2;
    x3c = {{2{t[31]}}, t[31:2]};
  end

  // stage 5 registers feed the divider directly
  assign b7lo   = b7_q < CSign;
  assign num    = b7lo ? b7_q << 1 : b7_q;
  assign den    = b4_q;
  assign tag_in = {b7lo, e4b_q | (b4_q == '0)};

  bpc_divider #(.TagW(TagW)) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v4b_q), .num_i(num), .den_i(den), .tag_i(tag_in),
    .valid_o(dv), .quo_o(quo), .tag_o(tag_out)
  );

  assign pa = tag_out[1] ? quo : quo << 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q  <= pa;
      tt_q  <= {{8{pa[31]}}, pa[31:8]};
      e5_q  <= tag_out[0];
      x2p_q <= CM7357 * pa;
      // t squared, then times 3038
      p6_q <= p5_q;
      x1_q <= tt_q * tt_q;
      x2_q <= x2p_q;
      e6_q <= e5_q;
      // final
      e7_q  <= e6_q;
      x1m_q <= x1_q * C3038;
      p7_q  <= p6_q;
      x2b_q <= x2_q;
    end
  end

  always_comb begin
    logic [31:0] s;
    s  = {{16{x1m_q[31]}}, x1m_q[31:16]} + {{16{x2b_q[31]}}, x2b_q[31:16]} + C3791;
    pf = p7_q + {{4{s[31]}}, s[31:4]};
  end

  // v7 lines up with e7/pf: dv->v5(p5) v6(p6,x1) v7(x1m,p7)
  assign valid_o   = v7_q;
  assign res_o.p   = e7_q ? 32'd0 : pf;
  assign res_o.err = e7_q;
endmodule

@@ sv/bpc_skid.sv @@
// ----------------------------------------------------------------------------
// bpc_skid
// small register queue with a full flag, used between and after the stages
// ----------------------------------------------------------------------------
module bpc_skid #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic             room_o
);
  // depth must be a power of two so the pointers wrap on their own; not checked
  localparam int unsigned AW = $clog2(Depth);
  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i && valid_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i && valid_o);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign room_o  = cnt_q < (AW+1)'(Depth);
endmodule

@@ sv/barometric_pressure_compensation_top.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// integer pressure compensation pipeline with decoupled front and back
// ----------------------------------------------------------------------------
// input channel s_axis: tdata holds raw_temperature [15:0] and raw_pressure
// [39:16]; output channel m_axis: tdata holds pressure_pa, tuser divide_error.
// calibration must be written over cfg_we_i/cfg_idx_i/cfg_wdata_i while idle;
// the block does not enforce this. throughput: one transfer per cycle while
// no queue is full. the delay from input transfer to the earliest output
// transfer is set by the two 32-stage radix-2 dividers (temperature then
// pressure), the multiply stages around them and the register in each queue.
// the front (temperature path) feeds the back (pressure path) through a
// small queue; the back feeds the result queue. when the receiver stalls
// the result queue fills and the back stops, then the middle queue fills,
// the front stops and s_axis_tready drops; nothing in flight is lost.
// reset clears the calibration, the pipeline valid bits and both queues.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // raw_temperature, raw_pressure
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pressure_pa
  output logic [7:0]  m_axis_tuser,  // divide_error
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import bpc_pkg::*;
  localparam int unsigned MidW = 32 + 24 + 1;
  logic [31:0]     reg_q [NumCfg];
  cal_t            cal;
  item_t           item;
  logic            acc, fv, bv, en_f, en_b, mid_v;
  logic [31:0]     b5;
  logic [23:0]     up;
  logic            ferr;
  logic [MidW-1:0] mid_in, mid_out;
  res_t            res, qout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumCfg; i++) reg_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgAc1Ac2: reg_q[CfgAc1Ac2] <= cfg_wdata_i;
        CfgAc3Ac4: reg_q[CfgAc3Ac4] <= cfg_wdata_i;
        CfgAc5Ac6: reg_q[CfgAc5Ac6] <= cfg_wdata_i;
        CfgB1B2:   reg_q[CfgB1B2]   <= cfg_wdata_i;
        CfgMcMd:   reg_q[CfgMcMd]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = sx16(reg_q[CfgAc1Ac2][31:16]); cal.ac2 = sx16(reg_q[CfgAc1Ac2][15:0]);
    cal.ac3 = sx16(reg_q[CfgAc3Ac4][31:16]); cal.ac4 = {16'd0, reg_q[CfgAc3Ac4][15:0]};
    cal.ac5 = {16'd0, reg_q[CfgAc5Ac6][31:16]}; cal.ac6 = {16'd0, reg_q[CfgAc5Ac6][15:0]};
    cal.b1  = sx16(reg_q[CfgB1B2][31:16]); cal.b2  = sx16(reg_q[CfgB1B2][15:0]);
    cal.mc  = sx16(reg_q[CfgMcMd][31:16]); cal.md  = sx16(reg_q[CfgMcMd][15:0]);
  end

  assign item.ut = s_axis_tdata[15:0];
  assign item.up = s_axis_tdata[39:16];
  assign s_axis_tready = en_f;
  assign acc = s_axis_tvalid & en_f;

  bpc_front u_front (
    .clk_i, .rst_ni, .en_i(en_f), .valid_i(acc), .item_i(item), .cal_i(cal),
    .valid_o(fv), .b5_o(b5), .up_o(up), .err_o(ferr)
  );

  assign mid_in = {ferr, up, b5};

  bpc_skid #(.Depth(QueueDepth), .Width(MidW)) u_mid (
    .clk_i, .rst_ni, .push_i(fv & en_f), .data_i(mid_in),
    .pop_i(en_b), .valid_o(mid_v), .data_o(mid_out), .room_o(en_f)
  );

  bpc_back u_back (
    .clk_i, .rst_ni, .en_i(en_b), .valid_i(mid_v), .b5_i(mid_out[31:0]),
    .up_i(mid_out[55:32]), .err_i(mid_out[56]), .cal_i(cal), .valid_o(bv), .res_o(res)
  );

  bpc_skid #(.Depth(QueueDepth), .Width($bits(res_t))) u_q (
    .clk_i, .rst_ni, .push_i(bv & en_b), .data_i(res),
    .pop_i(m_axis_tready), .valid_o(m_axis_tvalid), .data_o(qout), .room_o(en_b)
  );

  assign m_axis_tdata = qout.p;
  assign m_axis_tuser = {7'd0, qout.err};
endmodule

@@ sv/bpc_checker.sv @@
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks of the pressure compensation block
// ----------------------------------------------------------------------------
`include "barometric_pressure_compensation_top_assert.svh"
module bpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser
);
  `BPC_ASSERT_IMP(err_zero_p, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `BPC_ASSERT_IMP(tuser_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser[7:1] == '0)
  `BPC_ASSERT_NXT(hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind barometric_pressure_compensation_top bpc_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
